### rtl/ftg_pkg.sv
// Shared types, constants and helpers for the flat triangle Gouraud rasterizer.
// Used by every rasterizer module except ftg_checker; no dependencies.
`default_nettype none
package ftg_pkg;

  // Screen geometry
  localparam int SCREEN_W = 640;
  localparam int SCREEN_H = 480;

  // Field widths
  localparam int COORD_W  = 16;
  localparam int MAG_W    = 17;
  localparam int CHAN_W   = 4;
  localparam int COLOR_W  = 12;
  localparam int ADDR_W   = 19;
  localparam int POS_W    = 12;   // on-screen row or column, screen sides up to 4096
  localparam int PROD_W   = 25;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 32;

  // Accumulator counts
  localparam int ROW_ACCS  = 8;
  localparam int SPAN_ACCS = 3;
  localparam int EDGE_CHANS = 6;
  localparam int IDX_W     = 3;
  localparam int DIV_CNT_W = 5;

  localparam logic [IDX_W-1:0] ROW_LAST_IDX  = IDX_W'(ROW_ACCS - 1);
  localparam logic [IDX_W-1:0] SPAN_LAST_IDX = IDX_W'(SPAN_ACCS - 1);
  localparam logic [IDX_W-1:0] ROW_X_ACCS    = IDX_W'(2);

  localparam logic signed [COORD_W-1:0] SCREEN_W_S = COORD_W'(SCREEN_W);
  localparam logic signed [COORD_W-1:0] SCREEN_H_S = COORD_W'(SCREEN_H);

  // Request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic             latch_in;
    logic             capture_res;
    logic             start_load;
    logic             begin_span;
    logic             div_go;
    logic             div_apply;
    logic             div_row;
    logic [IDX_W-1:0] idx;
    logic             span_step;
    logic             row_step;
    logic             clr_active;
    logic             out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic req_start;
    logic active;
    logic span_more;
    logic row_more;
    logic div_done;
  } sts_t;

  // One result word
  typedef struct packed {
    logic               write_valid;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               final_res;
    logic               busy_res;
  } res_t;

  // Magnitude of a 17-bit two's complement difference
  function automatic logic [MAG_W-1:0] abs17(input logic [MAG_W-1:0] d);
    abs17 = d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
  endfunction

  // Magnitude of a 5-bit channel difference
  function automatic logic [CHAN_W-1:0] abs5(input logic [CHAN_W:0] d);
    logic [CHAN_W:0] m;
    m = d[CHAN_W] ? (~d + (CHAN_W+1)'(1)) : d;
    abs5 = m[CHAN_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/ftg_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on ftg_pkg for widths.
`default_nettype none
module ftg_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     go,
  input  wire logic [ftg_pkg::MAG_W-1:0] dividend,
  input  wire logic [ftg_pkg::MAG_W-1:0] divisor,
  output logic                          done,
  output logic [ftg_pkg::MAG_W-1:0]      quo,
  output logic [ftg_pkg::MAG_W-1:0]      rem
);

  logic [ftg_pkg::MAG_W:0]         rem_r, rem_nxt;
  logic [ftg_pkg::MAG_W-1:0]       quo_r, quo_nxt;
  logic [ftg_pkg::MAG_W-1:0]       den_r;
  logic [ftg_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            run_r, run_nxt;
  logic                            done_r, done_nxt;
  logic [ftg_pkg::MAG_W:0]         shifted, trial;

  // one restoring step
  assign shifted = {rem_r[ftg_pkg::MAG_W-1:0], quo_r[ftg_pkg::MAG_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = ftg_pkg::DIV_CNT_W'(ftg_pkg::MAG_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[ftg_pkg::MAG_W]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[ftg_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[ftg_pkg::MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - ftg_pkg::DIV_CNT_W'(1);
      if (cnt_r == ftg_pkg::DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (go) begin
      den_r <= divisor;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r[ftg_pkg::MAG_W-1:0];

endmodule
`default_nettype wire

### rtl/ftg_datapath.sv
// Rasterizer datapath: triangle state, Bresenham accumulators, result registers.
// Depends on ftg_pkg and ftg_div.
`default_nettype none
module ftg_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ftg_pkg::cmd_t                cmd,
  output ftg_pkg::sts_t                     sts,
  input  wire logic                         in_req,
  input  wire logic [ftg_pkg::IN_DATA_W-1:0] in_data,
  output ftg_pkg::res_t                     out_res
);

  // latched input word
  logic                                 req_r;
  logic signed [ftg_pkg::COORD_W-1:0]   ax_r, ay_r, lx_r, fy_r, rx_r;
  logic [ftg_pkg::COLOR_W-1:0]          ca_r, cl_r, cr_r;

  // triangle state
  logic                                 active_r;
  logic signed [ftg_pkg::COORD_W-1:0]   cur_row_r;
  logic                                 dir_y_neg_r;
  logic [ftg_pkg::MAG_W-1:0]            rows_left_r;
  logic [ftg_pkg::MAG_W-1:0]            height_r;
  logic signed [ftg_pkg::COORD_W-1:0]   edge_x_r [2];
  logic [ftg_pkg::CHAN_W-1:0]           edge_c_r [ftg_pkg::EDGE_CHANS];
  logic [ftg_pkg::MAG_W-1:0]            row_acc_r [ftg_pkg::ROW_ACCS];
  logic [ftg_pkg::MAG_W-1:0]            row_mag_r [ftg_pkg::ROW_ACCS];
  logic                                 row_neg_r [ftg_pkg::ROW_ACCS];
  logic signed [ftg_pkg::COORD_W-1:0]   span_x_r;
  logic                                 span_neg_r;
  logic [ftg_pkg::MAG_W-1:0]            span_len_r, span_left_r;
  logic [ftg_pkg::CHAN_W-1:0]           span_c_r [ftg_pkg::SPAN_ACCS];
  logic [ftg_pkg::MAG_W-1:0]            span_acc_r [ftg_pkg::SPAN_ACCS];
  logic [ftg_pkg::CHAN_W-1:0]           span_mag_r [ftg_pkg::SPAN_ACCS];
  logic                                 span_dneg_r [ftg_pkg::SPAN_ACCS];

  ftg_pkg::res_t res_r, out_r, res_nxt;

  // start and span differences
  logic [ftg_pkg::MAG_W-1:0] dy, dxl, dxr, dspan;
  logic [ftg_pkg::CHAN_W:0]  dca [3];
  logic [ftg_pkg::CHAN_W:0]  dcb [3];
  logic [ftg_pkg::CHAN_W:0]  dsc [3];

  assign dy    = {ay_r[15], ay_r} - {fy_r[15], fy_r};
  assign dxl   = {ax_r[15], ax_r} - {lx_r[15], lx_r};
  assign dxr   = {ax_r[15], ax_r} - {rx_r[15], rx_r};
  assign dspan = {edge_x_r[1][15], edge_x_r[1]} - {edge_x_r[0][15], edge_x_r[0]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dca[i] = {1'b0, ca_r[11-4*i -: 4]} - {1'b0, cl_r[11-4*i -: 4]};
      dcb[i] = {1'b0, ca_r[11-4*i -: 4]} - {1'b0, cr_r[11-4*i -: 4]};
      dsc[i] = {1'b0, edge_c_r[3+i]} - {1'b0, edge_c_r[i]};
    end
  end

  // divider operands
  logic [1:0]                 sidx;
  logic [ftg_pkg::IDX_W-1:0]  cidx;
  logic [ftg_pkg::MAG_W-1:0]  op_acc, op_mag, op_den, op_sum;
  logic                       div_done;
  logic [ftg_pkg::MAG_W-1:0]  quo, rem;

  assign sidx = cmd.idx[1:0];
  assign cidx = cmd.idx - ftg_pkg::ROW_X_ACCS;

  always_comb begin
    if (cmd.div_row) begin
      op_acc = row_acc_r[cmd.idx];
      op_mag = row_mag_r[cmd.idx];
      op_den = height_r;
    end else begin
      op_acc = span_acc_r[sidx];
      op_mag = ftg_pkg::MAG_W'(span_mag_r[sidx]);
      op_den = span_len_r;
    end
    op_sum = op_acc + op_mag;
  end

  ftg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (op_sum),
    .divisor  (op_den),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  // current position and result
  logic                            on_screen;
  logic [ftg_pkg::PROD_W-1:0]      prod;
  logic                            span_more, row_more;

  assign span_more = (span_left_r != '0);
  assign row_more  = (rows_left_r != '0);
  assign on_screen = (cur_row_r >= 16'sd0) && (cur_row_r < ftg_pkg::SCREEN_H_S) &&
                     (span_x_r >= 16'sd0) && (span_x_r < ftg_pkg::SCREEN_W_S);
  assign prod = ftg_pkg::PROD_W'(cur_row_r[ftg_pkg::POS_W-1:0]) *
                ftg_pkg::PROD_W'(ftg_pkg::SCREEN_W) +
                ftg_pkg::PROD_W'(span_x_r[ftg_pkg::POS_W-1:0]);

  always_comb begin
    res_nxt = '0;
    if (req_r == ftg_pkg::REQ_START) begin
      res_nxt.busy_res = 1'b1;
    end else if (active_r) begin
      if (on_screen) begin
        res_nxt.write_valid   = 1'b1;
        res_nxt.pixel_address = prod[ftg_pkg::ADDR_W-1:0];
        res_nxt.pixel_color   = {span_c_r[0], span_c_r[1], span_c_r[2]};
      end
      res_nxt.final_res = !span_more && !row_more;
      res_nxt.busy_res  = span_more || row_more;
    end
  end

  // active flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.start_load) begin
      active_r <= 1'b1;
    end else if (cmd.clr_active) begin
      active_r <= 1'b0;
    end
  end

  // input word and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r <= in_req;
      ax_r  <= in_data[15:0];
      ay_r  <= in_data[31:16];
      lx_r  <= in_data[47:32];
      fy_r  <= in_data[63:48];
      rx_r  <= in_data[79:64];
      ca_r  <= in_data[91:80];
      cl_r  <= in_data[103:92];
      cr_r  <= in_data[115:104];
    end
    if (cmd.capture_res) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  // triangle setup, row accumulator updates and row stepping
  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      cur_row_r    <= fy_r;
      dir_y_neg_r  <= dy[16];
      rows_left_r  <= ftg_pkg::abs17(dy);
      height_r     <= ftg_pkg::abs17(dy);
      edge_x_r[0]  <= lx_r;
      edge_x_r[1]  <= rx_r;
      row_mag_r[0] <= ftg_pkg::abs17(dxl);
      row_neg_r[0] <= dxl[16];
      row_mag_r[1] <= ftg_pkg::abs17(dxr);
      row_neg_r[1] <= dxr[16];
      for (int i = 0; i < 3; i++) begin
        edge_c_r[i]     <= cl_r[11-4*i -: 4];
        edge_c_r[3+i]   <= cr_r[11-4*i -: 4];
        row_mag_r[2+i]  <= ftg_pkg::MAG_W'(ftg_pkg::abs5(dca[i]));
        row_neg_r[2+i]  <= dca[i][4];
        row_mag_r[5+i]  <= ftg_pkg::MAG_W'(ftg_pkg::abs5(dcb[i]));
        row_neg_r[5+i]  <= dcb[i][4];
      end
      for (int j = 0; j < ftg_pkg::ROW_ACCS; j++) begin
        row_acc_r[j] <= '0;
      end
    end else if (cmd.div_apply && cmd.div_row) begin
      row_acc_r[cmd.idx] <= rem;
      if (cmd.idx < ftg_pkg::ROW_X_ACCS) begin
        edge_x_r[cmd.idx[0]] <= row_neg_r[cmd.idx] ?
                                edge_x_r[cmd.idx[0]] - $signed(quo[15:0]) :
                                edge_x_r[cmd.idx[0]] + $signed(quo[15:0]);
      end else begin
        edge_c_r[cidx] <= row_neg_r[cmd.idx] ? edge_c_r[cidx] - quo[3:0] :
                                               edge_c_r[cidx] + quo[3:0];
      end
    end
    if (cmd.row_step) begin
      cur_row_r   <= dir_y_neg_r ? cur_row_r - 16'sd1 : cur_row_r + 16'sd1;
      rows_left_r <= rows_left_r - ftg_pkg::MAG_W'(1);
    end
  end

  // span setup and stepping
  always_ff @(posedge clk) begin
    if (cmd.begin_span) begin
      span_x_r    <= edge_x_r[0];
      span_neg_r  <= dspan[16];
      span_len_r  <= ftg_pkg::abs17(dspan);
      span_left_r <= ftg_pkg::abs17(dspan);
      for (int i = 0; i < 3; i++) begin
        span_c_r[i]    <= edge_c_r[i];
        span_acc_r[i]  <= '0;
        span_mag_r[i]  <= ftg_pkg::abs5(dsc[i]);
        span_dneg_r[i] <= dsc[i][4];
      end
    end else begin
      if (cmd.div_apply && !cmd.div_row) begin
        span_acc_r[sidx] <= rem;
        span_c_r[sidx]   <= span_dneg_r[sidx] ? span_c_r[sidx] - quo[3:0] :
                                                span_c_r[sidx] + quo[3:0];
      end
      if (cmd.span_step) begin
        span_x_r    <= span_neg_r ? span_x_r - 16'sd1 : span_x_r + 16'sd1;
        span_left_r <= span_left_r - ftg_pkg::MAG_W'(1);
      end
    end
  end

  always_comb begin
    sts.req_start = (req_r == ftg_pkg::REQ_START);
    sts.active    = active_r;
    sts.span_more = span_more;
    sts.row_more  = row_more;
    sts.div_done  = div_done;
  end

  assign out_res = out_r;

endmodule
`default_nettype wire

### rtl/ftg_ctrl.sv
// Rasterizer controller: sequences setup, divisions, steps and the output word.
// Depends on ftg_pkg.
`default_nettype none
module ftg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output ftg_pkg::cmd_t      cmd,
  input  wire ftg_pkg::sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_LOAD   = 7'b0000100,
    S_SPAN   = 7'b0001000,
    S_DIV_GO = 7'b0010000,
    S_DIV_WT = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ftg_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       row_r, row_nxt;
  logic                       ovalid_r, ovalid_nxt;
  logic                       last_div;

  assign last_div = row_r ? (idx_r == ftg_pkg::ROW_LAST_IDX) :
                            (idx_r == ftg_pkg::SPAN_LAST_IDX);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    row_nxt   = row_r;
    cmd       = '0;
    cmd.idx     = idx_r;
    cmd.div_row = row_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.capture_res = 1'b1;
        idx_nxt         = '0;
        if (sts.req_start) begin
          state_nxt = S_LOAD;
        end else if (!sts.active) begin
          state_nxt = S_EMIT;
        end else if (sts.span_more) begin
          row_nxt   = 1'b0;
          state_nxt = S_DIV_GO;
        end else if (sts.row_more) begin
          row_nxt   = 1'b1;
          state_nxt = S_DIV_GO;
        end else begin
          cmd.clr_active = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_LOAD: begin
        cmd.start_load = 1'b1;
        state_nxt      = S_SPAN;
      end
      S_SPAN: begin
        cmd.begin_span = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (sts.div_done) begin
          cmd.div_apply = 1'b1;
          if (last_div) begin
            if (row_r) begin
              cmd.row_step = 1'b1;
              state_nxt    = S_SPAN;
            end else begin
              cmd.span_step = 1'b1;
              state_nxt     = S_EMIT;
            end
          end else begin
            idx_nxt   = idx_r + ftg_pkg::IDX_W'(1);
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_EMIT: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      row_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      row_r    <= row_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

endmodule
`default_nettype wire

### rtl/flat_triangle_gouraud_raster.sv
// Top level of the flat triangle Gouraud rasterizer.
// Depends on ftg_pkg, ftg_ctrl, ftg_datapath (and ftg_div below it).
//
// Usage:
//   Input stream: one word per request. in_tuser = 0 starts a triangle from the
//   coordinates and colors in in_tdata; in_tuser = 1 visits the next position.
//   Output stream: exactly one word per input word, in order. out_tuser is the
//   write strobe (0 when clipped, idle or start), out_tlast marks the last
//   position of the triangle, out_tdata carries address, color and busy.
//   Timing: one word at a time. A start passes through decode, triangle load
//   and span setup before its output word is loaded. Every Bresenham advance
//   runs through one shared 17-step serial divider (3 accumulators per pixel,
//   8 per row); a step onto a new row then sets up its new span. Steps past
//   the end of a triangle and the last position go from decode to the output
//   word. Input is accepted again in the cycle after the output word is loaded.
//   A finished word sits in the output register while the next input word is
//   accepted and worked on; if the receiver stalls, the block holds its next
//   word and does not accept further input until that word is moved out.
//   Reset (synchronous, active low) drops any triangle and empties the output.
`default_nettype none
module flat_triangle_gouraud_raster (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [15:0] apex_x, [31:16] apex_y, [47:32] left_x, [63:48] flat_y,
  // [79:64] right_x, [91:80] apex_color, [103:92] left_color,
  // [115:104] right_color, [119:116] zero
  input  wire logic [ftg_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] req_type
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [18:0] pixel_address, [30:19] pixel_color, [31] busy_res
  output logic [ftg_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] write_valid
  output logic                               out_tuser,
  // final_res
  output logic                               out_tlast
);

  ftg_pkg::cmd_t cmd;
  ftg_pkg::sts_t sts;
  ftg_pkg::res_t res;

  ftg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  ftg_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_req  (in_tuser),
    .in_data (in_tdata),
    .out_res (res)
  );

  // output word packing
  assign out_tdata = {res.busy_res, res.pixel_color, res.pixel_address};
  assign out_tuser = res.write_valid;
  assign out_tlast = res.final_res;

endmodule
`default_nettype wire

### rtl/ftg_checker.sv
// Port-level checks for the flat triangle Gouraud rasterizer, bound to the top.
// Depends on the top level's port list only.
`default_nettype none
module ftg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [119:0] in_tdata,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // a held word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // one word in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // last position leaves nothing pending
  a_last_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[31])
    else $error("last word still flagged busy");

  // no write strobe means no address and no color
  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[30:0] == 31'd0)
    else $error("unwritten word carries pixel data");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind flat_triangle_gouraud_raster ftg_checker u_ftg_checker (.*);
`default_nettype wire

### tb/tb_flat_triangle_gouraud_raster.sv
// Testbench for the flat triangle Gouraud rasterizer: drives start and step words,
// predicts every pixel word in-line and compares. Depends on ftg_pkg and the RTL top.
`timescale 1ns / 1ps
module tb_flat_triangle_gouraud_raster;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [ftg_pkg::IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [ftg_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  flat_triangle_gouraud_raster dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predicted pixel words
  ftg_pkg::res_t pixel_q[$];
  int mismatches;
  int words_seen;
  int words_sent;
  int pixels_written;
  int triangles;
  bit src_idle_en;
  bit sink_idle_en;
  bit sink_hold;
  int sink_idle_left;
  int cycle_cnt;

  // Rasterizer state mirror
  bit  m_active;
  int  m_row, m_dir_y;
  int  m_rows_left;
  int  m_edge_x[2];
  int  m_edge_c[6];
  int  m_row_acc[8];
  int  m_row_mag[9];
  int  m_row_dir[8];
  int  m_span_x, m_span_dir, m_span_len, m_span_left;
  int  m_span_c[3], m_span_acc[3], m_span_mag[3], m_span_dir_c[3];

  function automatic int sgn(int v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Bresenham advance: unit steps taken this time
  function automatic int bres_steps(ref int acc, input int mag, input int den);
    int k;
    if (den == 0) return 0;
    acc += mag;
    k = acc / den;
    acc -= k * den;
    return k;
  endfunction

  function automatic void load_span();
    int dc;
    m_span_x = m_edge_x[0];
    m_span_dir = sgn(m_edge_x[1] - m_edge_x[0]);
    m_span_len = iabs(m_edge_x[1] - m_edge_x[0]);
    m_span_left = m_span_len;
    for (int i = 0; i < 3; i++) begin
      dc = m_edge_c[3+i] - m_edge_c[i];
      m_span_c[i] = m_edge_c[i];
      m_span_acc[i] = 0;
      m_span_mag[i] = iabs(dc);
      m_span_dir_c[i] = sgn(dc);
    end
  endfunction

  // Works out the word a request produces and advances the mirror
  function automatic ftg_pkg::res_t raster_predict(input bit req,
                                                   input logic [ftg_pkg::IN_DATA_W-1:0] d);
    ftg_pkg::res_t r;
    int ax, ay, lx, fy, rx, ca, cl, cr, da, db, k, sh;
    r = '0;
    if (req == ftg_pkg::REQ_START) begin
      ax = $signed(d[15:0]); ay = $signed(d[31:16]); lx = $signed(d[47:32]);
      fy = $signed(d[63:48]); rx = $signed(d[79:64]);
      ca = d[91:80]; cl = d[103:92]; cr = d[115:104];
      m_row = fy;
      m_dir_y = sgn(ay - fy);
      m_rows_left = iabs(ay - fy);
      m_row_mag[0] = m_rows_left;
      m_edge_x[0] = lx; m_edge_x[1] = rx;
      m_row_mag[1] = iabs(ax - lx); m_row_dir[0] = sgn(ax - lx);
      m_row_mag[2] = iabs(ax - rx); m_row_dir[1] = sgn(ax - rx);
      for (int i = 0; i < 3; i++) begin
        sh = 8 - 4 * i;
        da = ((ca >> sh) & 15) - ((cl >> sh) & 15);
        db = ((ca >> sh) & 15) - ((cr >> sh) & 15);
        m_edge_c[i] = (cl >> sh) & 15;
        m_edge_c[3+i] = (cr >> sh) & 15;
        m_row_mag[3+i] = iabs(da); m_row_dir[2+i] = sgn(da);
        m_row_mag[6+i] = iabs(db); m_row_dir[5+i] = sgn(db);
      end
      for (int i = 0; i < 8; i++) m_row_acc[i] = 0;
      load_span();
      m_active = 1'b1;
      r.busy_res = 1'b1;
      return r;
    end
    if (!m_active) return r;
    if (m_row >= 0 && m_row < ftg_pkg::SCREEN_H && m_span_x >= 0 &&
        m_span_x < ftg_pkg::SCREEN_W) begin
      r.write_valid = 1'b1;
      r.pixel_address = ftg_pkg::ADDR_W'(m_row * ftg_pkg::SCREEN_W + m_span_x);
      r.pixel_color = {4'(m_span_c[0]), 4'(m_span_c[1]), 4'(m_span_c[2])};
    end
    if (m_span_left > 0) begin
      for (int i = 0; i < 3; i++) begin
        k = bres_steps(m_span_acc[i], m_span_mag[i], m_span_len);
        m_span_c[i] = (m_span_c[i] + m_span_dir_c[i] * k) & 15;
      end
      m_span_x += m_span_dir;
      m_span_left--;
    end else if (m_rows_left > 0) begin
      for (int i = 0; i < 2; i++) begin
        k = bres_steps(m_row_acc[i], m_row_mag[1+i], m_row_mag[0]);
        m_edge_x[i] += m_row_dir[i] * k;
      end
      for (int i = 0; i < 6; i++) begin
        k = bres_steps(m_row_acc[2+i], m_row_mag[3+i], m_row_mag[0]);
        m_edge_c[i] = (m_edge_c[i] + m_row_dir[2+i] * k) & 15;
      end
      m_row += m_dir_y;
      m_rows_left--;
      load_span();
    end else begin
      m_active = 1'b0;
      r.final_res = 1'b1;
    end
    r.busy_res = m_active;
    return r;
  endfunction

  // Sends one word, with optional leading idle burst
  task automatic send_word(input bit req, input logic [ftg_pkg::IN_DATA_W-1:0] d);
    @(posedge clk);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixel_q.push_back(raster_predict(req, d));
    words_sent++;
    if (req == ftg_pkg::REQ_START) triangles++;
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [ftg_pkg::IN_DATA_W-1:0] pack_tri(
      input logic [15:0] ax, ay, lx, fy, rx, input logic [11:0] ca, cl, cr);
    return {4'b0, cr, cl, ca, rx, fy, lx, ay, ax};
  endfunction

  task automatic send_start(input int ax, ay, lx, fy, rx, input logic [11:0] ca, cl, cr);
    send_word(ftg_pkg::REQ_START,
              pack_tri(16'(ax), 16'(ay), 16'(lx), 16'(fy), 16'(rx), ca, cl, cr));
  endtask

  // Steps until the triangle finishes (or cap reached)
  task automatic run_triangle(input int cap);
    int n;
    n = 0;
    send_word(ftg_pkg::REQ_STEP, ftg_pkg::IN_DATA_W'($urandom));
    n++;
    while (m_active && n < cap) begin
      send_word(ftg_pkg::REQ_STEP,
                ftg_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom}));
      n++;
    end
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    ftg_pkg::res_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.write_valid = out_tuser;
      got.pixel_address = out_tdata[18:0];
      got.pixel_color = out_tdata[30:19];
      got.busy_res = out_tdata[31];
      got.final_res = out_tlast;
      words_seen++;
      if (got.write_valid) pixels_written++;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected word %h", got);
      end else begin
        exp_r = pixel_q.pop_front();
        if (got != exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: wv %0d/%0d addr %0d/%0d color %h/%h last %0d/%0d busy %0d/%0d",
                     exp_r.write_valid, got.write_valid, exp_r.pixel_address,
                     got.pixel_address, exp_r.pixel_color, got.pixel_color,
                     exp_r.final_res, got.final_res, exp_r.busy_res, got.busy_res);
        end
      end
    end
  end

  // Receiver back-pressure, random idle bursts
  always @(posedge clk) begin
    if (!rst_n || sink_hold) begin
      out_tready <= 1'b0;
    end else if (sink_idle_left > 0) begin
      out_tready <= 1'b0;
      sink_idle_left--;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      sink_idle_left = $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 3000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed: extremes, idle steps, clipping, zero height and zero span
  task automatic test_directed();
    send_word(ftg_pkg::REQ_STEP, '1);
    send_start(320, 100, 318, 103, 322, 12'hfff, 12'h000, 12'h0f0);
    run_triangle(100);
    send_start(5, 5, 5, 5, 5, 12'h123, 12'h456, 12'h789);
    run_triangle(10);
    send_word(ftg_pkg::REQ_STEP, '0);
    send_start(-32768, 32767, 32767, 32766, -32768, 12'hfff, 12'h000, 12'hfff);
    repeat (4) send_word(ftg_pkg::REQ_STEP, '0);
    send_start(0, 481, 638, 478, 641, 12'h0f0, 12'hf0f, 12'h000);
    run_triangle(50);
    send_start(2, -1, -1, 1, 3, 12'ha5a, 12'h5a5, 12'h3c3);
    run_triangle(30);
    send_word(ftg_pkg::REQ_START, '1);
    send_word(ftg_pkg::REQ_STEP, '0);
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    sink_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
      end
      begin
        send_start(10, 0, 0, 3, 20, 12'hf00, 12'h00f, 12'h0f0);
        run_triangle(12);
      end
    join
    wait_drained();
  endtask

  // Random small triangles, mostly on screen, some far off
  task automatic test_random(input int items);
    int start_cnt, cx, cy;
    start_cnt = words_sent;
    while (words_sent - start_cnt < items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(ftg_pkg::REQ_START,
                  ftg_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom}));
        repeat ($urandom_range(1, 4)) send_word(ftg_pkg::REQ_STEP, '0);
      end else begin
        cx = $urandom_range(0, 680) - 20;
        cy = $urandom_range(0, 520) - 20;
        send_start(cx + $urandom_range(0, 12) - 6, cy + $urandom_range(0, 8) - 4,
                   cx - $urandom_range(0, 6), cy, cx + $urandom_range(0, 6),
                   12'($urandom), 12'($urandom), 12'($urandom));
        run_triangle($urandom_range(0, 7) == 0 ? 8 : 200);
      end
      if ($urandom_range(0, 30) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    sink_hold = 1'b0;
    sink_idle_left = 0;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    mismatches = 0; words_seen = 0; words_sent = 0; pixels_written = 0;
    triangles = 0; cycle_cnt = 0;
    m_active = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_backpressure();
    test_random(1100);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random(300);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Checked %0d of %0d words over %0d triangles, %0d pixels written.",
             words_seen, words_sent, triangles, pixels_written);
    $display("Covered clipping, idle steps, flat and far-off triangles and long stalls.");
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d, left over: %0d", mismatches, pixel_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/ftg_pkg.sv
rtl/ftg_div.sv
rtl/ftg_datapath.sv
rtl/ftg_ctrl.sv
rtl/flat_triangle_gouraud_raster.sv
rtl/ftg_checker.sv
tb/tb_flat_triangle_gouraud_raster.sv
